// ===== rtl/mfs_pkg.sv =====
// Shared constants, types and helper functions for the max-frequency stack.
// No dependencies; every other file in the block uses this package.
package mfs_pkg;

  localparam int CAPACITY = 64;

  // Number of 8-way levels needed to reduce CAPACITY leaves to one root.
  function automatic int tree_levels(int n);
    int lv;
    int span;
    lv   = 1;
    span = 8;
    while (span < n) begin
      span = span * 8;
      lv   = lv + 1;
    end
    return lv;
  endfunction

  localparam int TREE_LVLS = tree_levels(CAPACITY);
  localparam int TREE_PAD  = 1 << (3 * TREE_LVLS);
  localparam int IDX_W     = 3 * TREE_LVLS;
  localparam int LVL_W     = $clog2(CAPACITY + 1);
  localparam int CMP_W     = (IDX_W > LVL_W) ? IDX_W : LVL_W;
  localparam int CNT_W     = $clog2(TREE_LVLS + 1);

  // Offset of tree level l (1-based) inside the flat node array.
  function automatic int node_off(int l);
    int off;
    off = 0;
    for (int k = 1; k < l; k++) begin
      off = off + (TREE_PAD >> (3 * k));
    end
    return off;
  endfunction

  localparam int NODE_TOTAL = node_off(TREE_LVLS + 1);
  localparam int L1_CNT     = TREE_PAD >> 3;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    logic [LVL_W-1:0] key;
    logic [IDX_W-1:0] idx;
    logic [31:0]      value;
  } node_t;

  typedef struct packed {
    logic             push_we;
    logic             pop_sh;
    logic [31:0]      wr_value;
    logic [LVL_W-1:0] wr_level;
    logic [LVL_W-1:0] fill;
    logic [IDX_W-1:0] best;
    logic             look_pop;
    logic [31:0]      look_value;
  } cell_cmd_t;

  // a covers lower indices than b; on equal keys the newer entry (b) wins
  function automatic node_t pick(node_t a, node_t b);
    return (b.key >= a.key) ? b : a;
  endfunction

  function automatic node_t reduce8(node_t [7:0] k);
    node_t lo;
    node_t hi;
    lo = pick(pick(k[0], k[1]), pick(k[2], k[3]));
    hi = pick(pick(k[4], k[5]), pick(k[6], k[7]));
    return pick(lo, hi);
  endfunction

endpackage

// ===== rtl/mfs_cell.sv =====
// One storage cell of the frequency stack: holds one entry's value and level.
// Depends on mfs_pkg; shifts down from its upper neighbor when it or an entry below is popped.
module mfs_cell (
  input  logic                    clk_i,
  input  logic [mfs_pkg::IDX_W-1:0] idx_i,
  input  mfs_pkg::cell_cmd_t      cmd_i,
  input  logic [31:0]             nb_value_i,
  input  logic [mfs_pkg::LVL_W-1:0] nb_level_i,
  output logic [31:0]             value_o,
  output logic [mfs_pkg::LVL_W-1:0] level_o,
  output mfs_pkg::node_t          leaf_o
);

  logic [31:0]               value_q;
  logic [mfs_pkg::LVL_W-1:0] level_q;
  logic [mfs_pkg::CMP_W-1:0] my_idx;
  logic [mfs_pkg::CMP_W-1:0] fill;
  logic                      valid;
  logic                      hit;

  assign my_idx = mfs_pkg::CMP_W'(idx_i);
  assign fill   = mfs_pkg::CMP_W'(cmd_i.fill);
  assign valid  = my_idx < fill;

  // pop looks at every live entry, push only at copies of the pushed value
  assign hit = valid && (cmd_i.look_pop || (value_q == cmd_i.look_value));

  always_comb begin
    leaf_o       = '0;
    leaf_o.key   = hit ? level_q : '0;
    leaf_o.idx   = idx_i;
    leaf_o.value = value_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push_we && (my_idx == fill)) begin
      value_q <= cmd_i.wr_value;
      level_q <= cmd_i.wr_level;
    end else if (cmd_i.pop_sh && (my_idx >= mfs_pkg::CMP_W'(cmd_i.best)) &&
                 ((my_idx + mfs_pkg::CMP_W'(1)) < fill)) begin
      value_q <= nb_value_i;
      level_q <= nb_level_i;
    end
  end

  assign value_o = value_q;
  assign level_o = level_q;

endmodule

// ===== rtl/mfs_tree.sv =====
// Registered 8-way max tree over the cell leaves: finds the highest key,
// newest entry on ties. Depends on mfs_pkg (node_t, reduce8, tree geometry).
module mfs_tree (
  input  logic                                   clk_i,
  input  logic                                   load_i,
  input  mfs_pkg::node_t [mfs_pkg::CAPACITY-1:0] leaves_i,
  output mfs_pkg::node_t                         root_o
);

  mfs_pkg::node_t leaf   [mfs_pkg::TREE_PAD];
  mfs_pkg::node_t node_d [mfs_pkg::NODE_TOTAL];
  mfs_pkg::node_t node_q [mfs_pkg::NODE_TOTAL];

  for (genvar i = 0; i < mfs_pkg::TREE_PAD; i++) begin : g_leaf
    if (i < mfs_pkg::CAPACITY) begin : g_real
      assign leaf[i] = leaves_i[i];
    end else begin : g_pad
      assign leaf[i] = '{key: '0, idx: mfs_pkg::IDX_W'(i), value: '0};
    end
  end

  for (genvar l = 1; l <= mfs_pkg::TREE_LVLS; l++) begin : g_lvl
    for (genvar g = 0; g < (mfs_pkg::TREE_PAD >> (3 * l)); g++) begin : g_node
      mfs_pkg::node_t [7:0] kids;
      for (genvar k = 0; k < 8; k++) begin : g_kid
        if (l == 1) begin : g_from_leaf
          assign kids[k] = leaf[8 * g + k];
        end else begin : g_from_node
          assign kids[k] = node_q[mfs_pkg::node_off(l - 1) + 8 * g + k];
        end
      end
      assign node_d[mfs_pkg::node_off(l) + g] = mfs_pkg::reduce8(kids);
    end
  end

  // first level captures the beat; upper levels settle over the next cycles
  always_ff @(posedge clk_i) begin
    for (int n = 0; n < mfs_pkg::NODE_TOTAL; n++) begin
      if (load_i || (n >= mfs_pkg::L1_CNT)) begin
        node_q[n] <= node_d[n];
      end
    end
  end

  assign root_o = node_q[mfs_pkg::node_off(mfs_pkg::TREE_LVLS)];

endmodule

// ===== rtl/max_frequency_stack_top.sv =====
// Max-frequency stack, top level. Depends on mfs_pkg, mfs_cell and mfs_tree.
// A push stores a value with level 1 + (copies already held); a pop removes the entry
// with the highest level, newest first on ties, and returns its value. Each beat
// returns one result: status ok, empty (pop on empty stack, value 0) or full (push
// dropped, value 0). Entries live in a row of CAPACITY cells in push order; a pop shifts
// the cells above the removed entry down by one. Lookups go through a registered 8-way
// max tree whose depth is ceil(log8(CAPACITY)) levels; a result is committed once the
// root has settled through the tree registers, and the next input beat is taken after
// that commit. A commit waits while the output is held off; a result waiting in the
// output register does not block the next input.
module max_frequency_stack_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               opcode_i,
  input  logic signed [31:0] push_value_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         status_o,
  output logic signed [31:0] popped_value_o
);

  localparam int CAP = mfs_pkg::CAPACITY;

  logic                      busy_q;
  logic [mfs_pkg::CNT_W-1:0] cnt_q;
  logic [mfs_pkg::LVL_W-1:0] fill_q;
  logic [mfs_pkg::LVL_W-1:0] fill_d;
  mfs_pkg::op_e              op_q;
  logic [31:0]               pv_q;
  logic                      out_valid_q;
  mfs_pkg::status_e          status_q;
  mfs_pkg::status_e          status_d;
  logic [31:0]               popped_q;
  logic [31:0]               popped_d;

  logic                      accept;
  logic                      root_ready;
  logic                      commit;
  logic                      push_ok;
  logic                      pop_ok;

  mfs_pkg::cell_cmd_t        cmd;
  mfs_pkg::node_t            root;
  mfs_pkg::node_t [CAP-1:0]  leaves;
  logic [31:0]               cell_value [CAP];
  logic [mfs_pkg::LVL_W-1:0] cell_level [CAP];

  assign accept     = in_valid_i && !in_stall_o;
  assign root_ready = busy_q && (cnt_q == mfs_pkg::CNT_W'(mfs_pkg::TREE_LVLS));
  assign commit     = root_ready && (!out_valid_q || !out_stall_i);

  assign push_ok = (op_q == mfs_pkg::OP_PUSH) && (fill_q != mfs_pkg::LVL_W'(CAP));
  assign pop_ok  = (op_q == mfs_pkg::OP_POP) && (fill_q != '0);

  always_comb begin
    cmd            = '0;
    cmd.push_we    = commit && push_ok;
    cmd.pop_sh     = commit && pop_ok;
    cmd.wr_value   = pv_q;
    cmd.wr_level   = root.key + mfs_pkg::LVL_W'(1);
    cmd.fill       = fill_q;
    cmd.best       = root.idx;
    cmd.look_pop   = (mfs_pkg::op_e'(opcode_i) == mfs_pkg::OP_POP);
    cmd.look_value = push_value_i;
  end

  always_comb begin
    fill_d   = fill_q;
    status_d = mfs_pkg::ST_OK;
    popped_d = '0;
    priority if (push_ok) begin
      fill_d = fill_q + mfs_pkg::LVL_W'(1);
    end else if (pop_ok) begin
      fill_d   = fill_q - mfs_pkg::LVL_W'(1);
      popped_d = root.value;
    end else if (op_q == mfs_pkg::OP_PUSH) begin
      status_d = mfs_pkg::ST_FULL;
    end else begin
      status_d = mfs_pkg::ST_EMPTY;
    end
  end

  for (genvar i = 0; i < CAP; i++) begin : g_cell
    logic [31:0]               nb_value;
    logic [mfs_pkg::LVL_W-1:0] nb_level;
    if (i + 1 < CAP) begin : g_nb
      assign nb_value = cell_value[i + 1];
      assign nb_level = cell_level[i + 1];
    end else begin : g_top
      assign nb_value = '0;
      assign nb_level = '0;
    end

    mfs_cell u_cell (
      .clk_i      (clk_i),
      .idx_i      (mfs_pkg::IDX_W'(i)),
      .cmd_i      (cmd),
      .nb_value_i (nb_value),
      .nb_level_i (nb_level),
      .value_o    (cell_value[i]),
      .level_o    (cell_level[i]),
      .leaf_o     (leaves[i])
    );
  end

  mfs_tree u_tree (
    .clk_i    (clk_i),
    .load_i   (accept),
    .leaves_i (leaves),
    .root_o   (root)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      cnt_q       <= '0;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        busy_q <= 1'b1;
        cnt_q  <= mfs_pkg::CNT_W'(1);
      end else if (commit) begin
        busy_q <= 1'b0;
      end else if (busy_q && !root_ready) begin
        cnt_q <= cnt_q + mfs_pkg::CNT_W'(1);
      end

      if (commit) begin
        fill_q      <= fill_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q <= mfs_pkg::op_e'(opcode_i);
      pv_q <= push_value_i;
    end
    if (commit) begin
      status_q <= status_d;
      popped_q <= popped_d;
    end
  end

  assign in_stall_o     = busy_q;
  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign popped_value_o = popped_q;

endmodule

// ===== rtl/mfs_checker.sv =====
// Port-level checks for the max-frequency stack top level.
// Depends on mfs_pkg; bound to max_frequency_stack_top at the end of this file.
module mfs_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               opcode_i,
  input logic signed [31:0] push_value_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic [1:0]         status_o,
  input logic signed [31:0] popped_value_o
);

  // held result beat keeps its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o) &&
    $stable(popped_value_o))
    else $error("stalled result beat changed");

  // an accepted beat occupies the block until its result is registered
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken again before result");

  // a new result only comes out of work in progress
  a_result_has_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without accepted beat");

  // failed operations return zero
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != mfs_pkg::ST_OK) |-> popped_value_o == '0)
    else $error("error status with nonzero value");

  // a stalled input beat stays offered with the same payload
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(opcode_i) &&
    $stable(push_value_i))
    else $error("stalled input beat changed");

endmodule

bind max_frequency_stack_top mfs_checker u_mfs_checker (.*);
